// ----- sv/fpap_pkg.sv -----
// ----------------------------------------------------------------------------
// fpap_pkg: shared types and constants for the first-pivot partition block
// Field widths fixed by the interface, the default store depth and the
// control group that the sequencer hands to the element store.
// ----------------------------------------------------------------------------
package fpap_pkg;

    // Default number of element slots
    localparam int DEPTH_DEF = 16;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int BND_W   = 5;

    // Memory access strobes from sequencer to store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ----- sv/fpap_store.sv -----
// ----------------------------------------------------------------------------
// fpap_store: element store
// Simple dual-port memory, one write and one read address per cycle, read
// data registered. Contents are not cleared by reset.
// ----------------------------------------------------------------------------
module fpap_store #(
    parameter int DEPTH = fpap_pkg::DEPTH_DEF,
    localparam int IW = $clog2(DEPTH)
) (
    input  logic                              i_clk,
    input  fpap_pkg::t_mem_ctl                i_mem,
    input  logic [IW-1:0]                     i_waddr,
    input  logic [fpap_pkg::VALUE_W-1:0]      i_wdata,
    input  logic [IW-1:0]                     i_raddr,
    output logic [fpap_pkg::VALUE_W-1:0]      o_rdata
);

    logic [fpap_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic [fpap_pkg::VALUE_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_mem.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fpap_ctrl.sv -----
// ----------------------------------------------------------------------------
// fpap_ctrl: load / partition / emit sequencer
// Drives all reads and writes of the element store: loads items, counts the
// small section, moves the pivot, runs the two-pointer scan with swaps and
// streams the partitioned array out with its slot information.
// ----------------------------------------------------------------------------
module fpap_ctrl #(
    parameter int DEPTH = fpap_pkg::DEPTH_DEF,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [fpap_pkg::VALUE_W-1:0]      i_value,
    input  logic                              i_last,
    output logic                              o_busy,
    output fpap_pkg::t_mem_ctl                o_mem,
    output logic [IW-1:0]                     o_waddr,
    output logic [fpap_pkg::VALUE_W-1:0]      o_wdata,
    output logic [IW-1:0]                     o_raddr,
    input  logic [fpap_pkg::VALUE_W-1:0]      i_rdata,
    output logic                              o_strobe,
    output logic [fpap_pkg::POS_W-1:0]        o_position,
    output logic [fpap_pkg::BND_W-1:0]        o_boundary,
    output logic                              o_in_large,
    output logic                              o_end_of_array
);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_PIV     = 4'd1;
    localparam logic [3:0] S_PIV_CAP = 4'd2;
    localparam logic [3:0] S_CNT     = 4'd3;
    localparam logic [3:0] S_SWP_RD  = 4'd4;
    localparam logic [3:0] S_SWP_W0  = 4'd5;
    localparam logic [3:0] S_SWP_W1  = 4'd6;
    localparam logic [3:0] S_OUTER   = 4'd7;
    localparam logic [3:0] S_LRD     = 4'd8;
    localparam logic [3:0] S_LCMP    = 4'd9;
    localparam logic [3:0] S_RRD     = 4'd10;
    localparam logic [3:0] S_RCMP    = 4'd11;
    localparam logic [3:0] S_DEC     = 4'd12;
    localparam logic [3:0] S_SW0     = 4'd13;
    localparam logic [3:0] S_SW1     = 4'd14;
    localparam logic [3:0] S_EMIT    = 4'd15;

    logic [3:0]                   r_state;
    logic [CW-1:0]                r_n;       // loaded element count
    logic [CW-1:0]                r_ptr;     // count / emit address
    logic                         r_cval;    // count read in flight
    logic [IW-1:0]                r_cnt;     // small-section size = pivot slot
    logic [fpap_pkg::VALUE_W-1:0] r_pivot;
    logic [CW-1:0]                r_lo;      // left pointer
    logic [CW-1:0]                r_h1;      // right pointer plus one
    logic [fpap_pkg::VALUE_W-1:0] r_lval;    // value where left scan stopped
    logic                         r_ev;
    logic [IW-1:0]                r_ek;
    logic                         r_elast;

    logic          w_accept;
    logic          w_le;
    logic [CW-1:0] w_h1m1;
    logic [CW-1:0] w_idx1;
    logic [IW-1:0] w_bnd;
    logic          w_cnt_more;

    assign w_accept   = i_start && (r_state == S_LOAD);
    assign w_le       = $signed(i_rdata) <= $signed(r_pivot);
    assign w_h1m1     = r_h1 - CW'(1);
    assign w_idx1     = CW'(r_cnt) + CW'(1);
    assign w_bnd      = (r_cnt == '0) ? IW'(1) : r_cnt;
    assign w_cnt_more = r_ptr < r_n;

    // Memory access per state; reads and writes never share a cycle
    always_comb begin
        o_mem   = '0;
        o_waddr = '0;
        o_wdata = r_lval;
        o_raddr = '0;
        unique case (r_state)
            S_LOAD: begin
                o_mem.wr_en = w_accept && (r_n < CW'(DEPTH));
                o_waddr     = r_n[IW-1:0];
                o_wdata     = i_value;
            end
            S_PIV: begin
                o_mem.rd_en = 1'b1;
            end
            S_CNT: begin
                o_mem.rd_en = w_cnt_more;
                o_raddr     = r_ptr[IW-1:0];
            end
            S_SWP_RD: begin
                o_mem.rd_en = 1'b1;
                o_raddr     = r_cnt;
            end
            S_SWP_W0: begin
                o_mem.wr_en = 1'b1;
                o_waddr     = r_cnt;
                o_wdata     = r_pivot;
            end
            S_SWP_W1: begin
                // read data still holds the old pivot-slot value
                o_mem.wr_en = 1'b1;
                o_wdata     = i_rdata;
            end
            S_LRD: begin
                o_mem.rd_en = r_lo < r_n;
                o_raddr     = r_lo[IW-1:0];
            end
            S_RRD: begin
                o_mem.rd_en = r_h1 != '0;
                o_raddr     = w_h1m1[IW-1:0];
            end
            S_SW0: begin
                // read data still holds the value where the right scan stopped
                o_mem.wr_en = 1'b1;
                o_waddr     = r_lo[IW-1:0];
                o_wdata     = i_rdata;
            end
            S_SW1: begin
                o_mem.wr_en = 1'b1;
                o_waddr     = w_h1m1[IW-1:0];
                o_wdata     = r_lval;
            end
            S_EMIT: begin
                o_mem.rd_en = 1'b1;
                o_raddr     = r_ptr[IW-1:0];
            end
            default: begin
                o_mem = '0;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_cval  <= 1'b0;
            r_ev    <= 1'b0;
        end else begin
            r_ev <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if (r_n < CW'(DEPTH)) begin
                            r_n <= r_n + CW'(1);
                        end
                        if (i_last) begin
                            r_state <= S_PIV;
                        end
                    end
                end
                S_PIV: begin
                    r_state <= S_PIV_CAP;
                end
                S_PIV_CAP: begin
                    r_pivot <= i_rdata;
                    r_ptr   <= CW'(1);
                    r_cnt   <= '0;
                    r_cval  <= 1'b0;
                    r_state <= S_CNT;
                end
                S_CNT: begin
                    // issue one read per cycle, compare the data in the next cycle
                    if (w_cnt_more) begin
                        r_ptr <= r_ptr + CW'(1);
                    end
                    r_cval <= w_cnt_more;
                    if (r_cval && w_le) begin
                        r_cnt <= r_cnt + IW'(1);
                    end
                    if (!w_cnt_more && !r_cval) begin
                        r_state <= S_SWP_RD;
                    end
                end
                S_SWP_RD: begin
                    r_state <= S_SWP_W0;
                end
                S_SWP_W0: begin
                    r_state <= S_SWP_W1;
                end
                S_SWP_W1: begin
                    r_lo    <= '0;
                    r_h1    <= r_n;
                    r_state <= S_OUTER;
                end
                S_OUTER: begin
                    if (r_lo < r_h1) begin
                        r_state <= S_LRD;
                    end else begin
                        r_ptr   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_LRD: begin
                    r_state <= (r_lo < r_n) ? S_LCMP : S_RRD;
                end
                S_LCMP: begin
                    r_lval <= i_rdata;
                    if (w_le) begin
                        r_lo    <= r_lo + CW'(1);
                        r_state <= S_LRD;
                    end else begin
                        r_state <= S_RRD;
                    end
                end
                S_RRD: begin
                    r_state <= (r_h1 != '0) ? S_RCMP : S_DEC;
                end
                S_RCMP: begin
                    if (!w_le) begin
                        r_h1    <= w_h1m1;
                        r_state <= S_RRD;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    // swap only across the pivot slot, else stop
                    if ((r_h1 > w_idx1) && (r_lo < CW'(r_cnt))) begin
                        r_state <= S_SW0;
                    end else begin
                        r_ptr   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_SW0: begin
                    r_state <= S_SW1;
                end
                S_SW1: begin
                    r_lo    <= r_lo + CW'(1);
                    r_h1    <= w_h1m1;
                    r_state <= S_OUTER;
                end
                S_EMIT: begin
                    r_ev    <= 1'b1;
                    r_ek    <= r_ptr[IW-1:0];
                    r_elast <= (r_ptr + CW'(1)) == r_n;
                    r_ptr   <= r_ptr + CW'(1);
                    if ((r_ptr + CW'(1)) == r_n) begin
                        r_n     <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Result fields
    assign o_busy         = r_state != S_LOAD;
    assign o_strobe       = r_ev;
    assign o_position     = fpap_pkg::POS_W'(r_ek);
    assign o_boundary     = fpap_pkg::BND_W'(w_bnd);
    assign o_in_large     = r_ek >= w_bnd;
    assign o_end_of_array = r_ev && r_elast;

    // Checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(DEPTH))
        else $error("load count beyond depth");

    a_no_rw_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem.wr_en && o_mem.rd_en))
        else $error("store read and write in one cycle");

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_EMIT))
        else $error("result strobe outside emit");

    a_end_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_end_of_array |=> !o_strobe)
        else $error("result after final slot");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LRD || r_state == S_RRD) |-> (r_lo <= r_n && r_h1 <= r_n))
        else $error("scan pointer out of range");

endmodule

// ----- sv/first_pivot_array_partition.sv -----
// ----------------------------------------------------------------------------
// first_pivot_array_partition: quicksort partition step, first element pivot
// Sequence: loads one item per cycle while not busy; after the last item it
//   reads the pivot, runs the count pass and moves the pivot; each scan pass
//   then tests the pointers, scans from the left and then from the right,
//   decides whether to swap across the pivot slot and swaps; results then
//   stream one per cycle, the first in the cycle after the emit pass begins.
// Arrays: the next array loads once the final slot has been read out.
// Reset: synchronous, active low; clears the sequencer and load count only,
//   the element store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module first_pivot_array_partition #(
    parameter int DEPTH = fpap_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [fpap_pkg::VALUE_W-1:0]      i_value,
    input  logic                              i_last,
    output logic                              busy,
    output logic                              o_strobe,
    output logic [fpap_pkg::VALUE_W-1:0]      o_element,
    output logic [fpap_pkg::POS_W-1:0]        o_position,
    output logic [fpap_pkg::BND_W-1:0]        o_boundary,
    output logic                              o_in_large,
    output logic                              o_end_of_array
);

    localparam int IW = $clog2(DEPTH);

    fpap_pkg::t_mem_ctl            w_mem;
    logic [IW-1:0]                 w_waddr;
    logic [IW-1:0]                 w_raddr;
    logic [fpap_pkg::VALUE_W-1:0]  w_wdata;
    logic [fpap_pkg::VALUE_W-1:0]  w_rdata;

    // Sequencer
    fpap_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_busy         (busy),
        .o_mem          (w_mem),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_strobe       (o_strobe),
        .o_position     (o_position),
        .o_boundary     (o_boundary),
        .o_in_large     (o_in_large),
        .o_end_of_array (o_end_of_array)
    );

    // Element store; its read register carries the result element
    fpap_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_mem   (w_mem),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_element = w_rdata;

endmodule

// ----- tb/first_pivot_array_partition_test.sv -----
// ----------------------------------------------------------------------------
// first_pivot_array_partition_test: self-checking bench for the partition block
// Loads arrays of signed values one transaction at a time, predicts the
// partition around the first element, and checks every emitted slot against
// the prediction in order. Covers single elements, extremes, duplicates,
// rising and falling inputs and arrays that overflow the store.
// ----------------------------------------------------------------------------
module first_pivot_array_partition_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = fpap_pkg::DEPTH_DEF;
    localparam int VALUE_W     = fpap_pkg::VALUE_W;
    localparam int POS_W       = fpap_pkg::POS_W;
    localparam int BND_W       = fpap_pkg::BND_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 60;
    localparam int MAX_REPORTS = 10;

    localparam logic [VALUE_W-1:0] VMIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VMAX = 32'h7FFF_FFFF;

    // Value styles for random arrays
    typedef enum int {
        ST_FULL, ST_NARROW, ST_EXTREME, ST_RISING, ST_FALLING
    } t_value_style;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               last;
        int                 gap;
        bit                 wait_drain;
    } t_load_item;

    typedef struct {
        logic signed [VALUE_W-1:0] element;
        logic [POS_W-1:0]          position;
        logic [BND_W-1:0]          boundary;
        logic                      in_large;
        logic                      end_of_array;
    } t_slot_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_last = 1'b0;
    logic               busy;
    logic               o_strobe;
    logic [VALUE_W-1:0] o_element;
    logic [POS_W-1:0]   o_position;
    logic [BND_W-1:0]   o_boundary;
    logic               o_in_large;
    logic               o_end_of_array;

    first_pivot_array_partition #(.DEPTH(DEPTH)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_value        (i_value),
        .i_last         (i_last),
        .busy           (busy),
        .o_strobe       (o_strobe),
        .o_element      (o_element),
        .o_position     (o_position),
        .o_boundary     (o_boundary),
        .o_in_large     (o_in_large),
        .o_end_of_array (o_end_of_array)
    );

    // Stimulus and prediction state
    t_load_item   pending_loads[$];
    t_slot_result expected_slots[$];

    logic signed [VALUE_W-1:0] shadow_store [DEPTH];
    int shadow_count = 0;

    int idle_left       = 0;
    int cur_gap         = 0;
    int loads_accepted  = 0;
    int arrays_done     = 0;
    int overflow_arrays = 0;
    int slots_checked   = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;
    int stored_planned  = 0;

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Reset: held low from time zero, then released
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Partition the shadow array around its first element and queue the slots
    function automatic void predict_partition();
        logic signed [VALUE_W-1:0] pivot;
        logic signed [VALUE_W-1:0] tmp;
        t_slot_result slot;
        int n, cnt, lo, hi, bnd;
        n     = shadow_count;
        pivot = shadow_store[0];
        cnt   = 0;
        for (int i = 1; i < n; i++)
            if (shadow_store[i] <= pivot)
                cnt++;
        tmp                = shadow_store[cnt];
        shadow_store[cnt]  = shadow_store[0];
        shadow_store[0]    = tmp;
        lo = 0;
        hi = n - 1;
        while (lo <= hi) begin
            while (lo <= n - 1 && shadow_store[lo] <= pivot)
                lo++;
            while (hi >= 0 && !(shadow_store[hi] <= pivot))
                hi--;
            if (hi > cnt && lo < cnt) begin
                tmp              = shadow_store[lo];
                shadow_store[lo] = shadow_store[hi];
                shadow_store[hi] = tmp;
                lo++;
                hi--;
            end else begin
                break;
            end
        end
        bnd = (cnt == 0) ? 1 : cnt;
        for (int k = 0; k < n; k++) begin
            slot.element      = shadow_store[k];
            slot.position     = POS_W'(k);
            slot.boundary     = BND_W'(bnd);
            slot.in_large     = (k >= bnd);
            slot.end_of_array = (k + 1 == n);
            expected_slots.push_back(slot);
        end
    endfunction

    // Store one accepted transaction; partition when it closes an array
    function automatic void record_load(logic [VALUE_W-1:0] value, logic last);
        if (shadow_count < DEPTH) begin
            shadow_store[shadow_count] = value;
            shadow_count++;
        end else if (last) begin
            overflow_arrays++;
        end
        if (last) begin
            predict_partition();
            shadow_count = 0;
            arrays_done++;
        end
    endfunction

    function automatic void add_item(logic [VALUE_W-1:0] value, logic last, bit gaps_on,
                                     bit wait_drain);
        t_load_item item;
        item.value      = value;
        item.last       = last;
        item.gap        = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        item.wait_drain = wait_drain;
        pending_loads.push_back(item);
    endfunction

    function automatic void add_array(logic [VALUE_W-1:0] vals[$], bit wait_drain);
        for (int k = 0; k < vals.size(); k++)
            add_item(vals[k], k == vals.size() - 1, 1'b1, wait_drain && k == 0);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(t_value_style style, int k);
        logic [VALUE_W-1:0] v;
        case (style)
            ST_NARROW: begin
                v = VALUE_W'($urandom_range(0, 8)) - 32'd4;
            end
            ST_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: v = VMIN;
                    1: v = VMAX;
                    2: v = '0;
                    3: v = '1;
                    4: v = 32'd1;
                    default: v = $urandom;
                endcase
            end
            ST_RISING: begin
                v = VALUE_W'($urandom_range(0, 20)) + VALUE_W'(k * 9) - 32'd40;
            end
            ST_FALLING: begin
                v = 32'd60 - VALUE_W'(k * 9) + VALUE_W'($urandom_range(0, 20));
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    // Driver: hold an item until accepted, then insert its gap or move on
    always @(posedge i_clk) begin
        t_load_item nxt;
        bit accepted;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left = 0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                record_load(i_value, i_last);
                loads_accepted++;
                idle_left = cur_gap;
            end
            if (!start || accepted) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_loads.size() == 0) begin
                    start <= 1'b0;
                end else if (pending_loads[0].wait_drain && expected_slots.size() != 0) begin
                    // Hold off until every queued slot has come out
                    start <= 1'b0;
                end else begin
                    nxt     = pending_loads.pop_front();
                    i_value <= nxt.value;
                    i_last  <= nxt.last;
                    cur_gap = nxt.gap;
                    start   <= 1'b1;
                end
            end
        end
    end

    // Monitor: compare each strobed slot with the oldest prediction
    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_slots.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected slot: element %0d position %0d boundary %0d",
                             $realtime, $signed(o_element), o_position, o_boundary);
            end else begin
                want = expected_slots.pop_front();
                slots_checked++;
                if (o_element !== want.element || o_position !== want.position ||
                    o_boundary !== want.boundary || o_in_large !== want.in_large ||
                    o_end_of_array !== want.end_of_array) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $write("[%0t] slot mismatch: exp elem %0d pos %0d bnd %0d large %b end %b",
                               $realtime, want.element, want.position, want.boundary,
                               want.in_large, want.end_of_array);
                        $display(" | got elem %0d pos %0d bnd %0d large %b end %b",
                                 $signed(o_element), o_position, o_boundary, o_in_large,
                                 o_end_of_array);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d slots outstanding",
                     cycle_count, expected_slots.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Build the stimulus, then wait for the block to drain and report
    initial begin
        logic [VALUE_W-1:0] vals[$];
        t_value_style style;
        int len, pick;
        bit gaps_on, drain_mid_done;

        // Directed arrays: single elements, pairs, duplicates, extremes
        vals = '{VMIN};
        add_array(vals, 1'b0);
        vals = '{VMAX};
        add_array(vals, 1'b0);
        vals = '{32'd0, 32'hFFFF_FFFF};
        add_array(vals, 1'b0);
        vals = '{32'hFFFF_FFFF, 32'd0};
        add_array(vals, 1'b0);
        vals = '{32'd5, 32'd5, 32'd5};
        add_array(vals, 1'b0);
        vals = '{VMIN, VMAX, 32'd0, 32'hFFFF_FFFF, 32'd1};
        add_array(vals, 1'b0);
        vals = '{VMAX, VMIN, 32'd7, VMAX};
        add_array(vals, 1'b0);
        vals = '{32'd3, 32'd9, 32'd1, 32'd7, 32'd2, 32'd8};
        add_array(vals, 1'b0);

        // Random arrays: mostly short, some up to the store depth, a few overflowing the store
        drain_mid_done = 1'b0;
        stored_planned = 0;
        while (stored_planned < 450) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(1, 8);
            else if (pick < 9)
                len = $urandom_range(9, DEPTH);
            else
                len = $urandom_range(DEPTH + 1, DEPTH + 4);
            style   = t_value_style'($urandom_range(0, 4));
            gaps_on = (stored_planned < 180) ||
                      (stored_planned >= 240 && stored_planned < 380);
            for (int k = 0; k < len; k++)
                add_item(pick_value(style, k), k == len - 1, gaps_on,
                         k == 0 && (stored_planned == 0 ||
                                    (!drain_mid_done && stored_planned >= 220)));
            if (stored_planned >= 220)
                drain_mid_done = 1'b1;
            stored_planned += (len < DEPTH) ? len : DEPTH;
        end

        @(posedge i_clk);
        while (!i_rst_n || pending_loads.size() != 0 || start)
            @(posedge i_clk);
        while (expected_slots.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("covered %0d loads in %0d arrays (%0d overflowing), %0d slots checked",
                 loads_accepted, arrays_done, overflow_arrays, slots_checked);
        $display("mismatches %0d, slots never seen %0d", mismatch_count,
                 expected_slots.size());
        if (mismatch_count == 0 && expected_slots.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/fpap_pkg.sv
sv/fpap_store.sv
sv/fpap_ctrl.sv
sv/first_pivot_array_partition.sv
tb/first_pivot_array_partition_test.sv
